>>> rtl/lzfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lzfd_pkg;

   // result codes carried on the result tuser
   typedef enum logic [2:0] {
      ST_NONE   = 3'd0,
      ST_BYTE   = 3'd1,
      ST_BUSY   = 3'd2,
      ST_BADALG = 3'd3,
      ST_BADOFS = 3'd4,
      ST_EMPTY  = 3'd5
   } status_type;

   // request kind carried on the request tuser
   typedef enum logic {
      KIND_FEED = 1'b0,
      KIND_PULL = 1'b1
   } kind_type;

   // parser phase
   typedef enum logic [3:0] {
      PH_HDR0      = 4'd0,
      PH_HDR1      = 4'd1,
      PH_HDR2      = 4'd2,
      PH_HDR3      = 4'd3,
      PH_SIZE0     = 4'd4,
      PH_SIZE1     = 4'd5,
      PH_SIZE2     = 4'd6,
      PH_SIZE3     = 4'd7,
      PH_FLAGS     = 4'd8,
      PH_TOKEN     = 4'd9,
      PH_OFS2      = 4'd10,
      PH_EXT3_B1   = 4'd11,
      PH_EXT3_OFS  = 4'd12,
      PH_EXT4_B1   = 4'd13,
      PH_EXT4_B2   = 4'd14,
      PH_EXT4_OFS  = 4'd15
   } phase_type;

   // one classified request waiting in the queue
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } item_type;

   localparam int DIST_W = 13;
   localparam int RUN_W  = 17;

   // run length biases of the token forms
   localparam logic [RUN_W-1:0] LEN_BIAS_NORMAL = 17'd3;
   localparam logic [RUN_W-1:0] LEN_BIAS_EXT2   = 17'd1;
   localparam logic [RUN_W-1:0] LEN_BIAS_EXT3   = 17'd17;
   localparam logic [RUN_W-1:0] LEN_BIAS_EXT4   = 17'd273;

   // register map
   localparam logic [1:0] CSR_ALG_ADDR  = 2'd0;
   localparam logic [3:0] ALG_RESET     = 4'd1;

endpackage

`default_nettype wire

>>> rtl/lzfd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lzfd_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [7:0]           req_tdata,
   input  wire  [0:0]           req_tuser,
   output logic                 q_valid,
   input  wire                  q_ready,
   output lzfd_pkg::item_type   q_item
);
   import lzfd_pkg::*;

   item_type   slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   item_type   new_item;

   // classify the incoming beat
   always_comb begin
      new_item.kind = req_tuser[0] ? KIND_PULL : KIND_FEED;
      new_item.data = req_tdata;
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_item     = slot_ff[rptr_ff];

   // queue pointers
   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lzfd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lzfd_back #(
   parameter int HISTORY_DEPTH = 4096
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire  [3:0]           alg_id,
   input  wire                  q_valid,
   output logic                 q_ready,
   input  wire  lzfd_pkg::item_type q_item,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic [2:0]           rsp_tuser,
   output logic                 rsp_tlast
);
   import lzfd_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

   // parser state
   phase_type         phase_ff, phase_in;
   logic [31:0]       hs_ff, hs_in;
   logic [31:0]       rem_ff, rem_in;
   logic              ext_ff, ext_in;
   logic [7:0]        flag_ff, flag_in;
   logic [2:0]        fidx_ff, fidx_in;
   logic [23:0]       tok_ff, tok_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [CW-1:0]     pc_ff, pc_in;

   // result stage
   logic              b_valid_ff;
   status_type        b_status_ff;
   logic [7:0]        b_lit_ff;
   logic              b_last_ff;
   logic              b_wr_ff;
   logic              b_ram_ff;
   logic              b_fwd_ff;
   logic [AW-1:0]     b_waddr_ff;
   logic [7:0]        ram_q_ff;
   logic [7:0]        last_byte_ff;
   logic [7:0]        b_byte;

   logic [7:0]        hist_mem [HISTORY_DEPTH];

   logic              adv, fire, wr_en;
   logic [7:0]        b;
   logic [31:0]       hs_shift;
   logic [31:0]       rem_dec;
   logic              at_end;
   logic [RUN_W-1:0]  num;
   logic [DIST_W-1:0] dist_calc;
   logic [7:0]        tok_r;
   logic [AW-1:0]     rd_addr;
   logic              fwd;

   status_type        a_status;
   logic [7:0]        a_lit;
   logic              a_last, a_prod, a_ram;

   assign adv     = !b_valid_ff || rsp_tready;
   assign q_ready = adv;
   assign fire    = q_valid && adv;
   assign b       = q_item.data;
   assign hs_shift = {b, hs_ff[31:8]};
   assign rem_dec = (rem_ff != 32'd0) ? rem_ff - 32'd1 : 32'd0;
   assign at_end  = (rem_dec == 32'd0);
   assign rd_addr = wp_ff - dist_ff[AW-1:0];
   assign fwd     = b_valid_ff && b_wr_ff && (dist_ff == DIST_W'(1));

   // back-reference length and distance from the collected token bytes
   always_comb begin
      tok_r = tok_ff[7:0];
      case (phase_ff)
         PH_EXT3_OFS: num = RUN_W'({tok_ff[11:8], tok_r[7:4]}) + LEN_BIAS_EXT3;
         PH_EXT4_OFS: num = RUN_W'({tok_ff[19:16], tok_ff[15:8], tok_r[7:4]})
                            + LEN_BIAS_EXT4;
         default:     num = RUN_W'(tok_r[7:4]) + (ext_ff ? LEN_BIAS_EXT2 : LEN_BIAS_NORMAL);
      endcase
      dist_calc = DIST_W'({tok_r[3:0], b}) + DIST_W'(1);
   end

   // parser next state
   always_comb begin
      phase_in = phase_ff;
      hs_in    = hs_ff;
      rem_in   = rem_ff;
      ext_in   = ext_ff;
      flag_in  = flag_ff;
      fidx_in  = fidx_ff;
      tok_in   = tok_ff;
      run_in   = run_ff;
      dist_in  = dist_ff;
      wp_in    = wp_ff;
      pc_in    = pc_ff;
      a_status = ST_NONE;
      a_lit    = 8'd0;
      a_last   = 1'b0;
      a_prod   = 1'b0;
      a_ram    = 1'b0;
      if (fire) begin
         if (q_item.kind == KIND_PULL) begin
            if (run_ff == '0) begin
               a_status = ST_EMPTY;
            end else begin
               a_status = ST_BYTE;
               a_ram    = 1'b1;
               a_prod   = 1'b1;
               run_in   = run_ff - RUN_W'(1);
            end
         end else if (run_ff != '0) begin
            a_status = ST_BUSY;
         end else begin
            unique case (phase_ff)
               PH_HDR0, PH_HDR1, PH_HDR2, PH_SIZE0, PH_SIZE1, PH_SIZE2: begin
                  hs_in    = hs_shift;
                  phase_in = phase_type'(phase_ff + 4'd1);
               end
               PH_HDR3: begin
                  if (hs_shift[3:0] != alg_id) begin
                     a_status = ST_BADALG;
                     phase_in = PH_HDR0;
                     hs_in    = 32'd0;
                     run_in   = '0;
                  end else begin
                     ext_in = (hs_shift[7:4] != 4'd0);
                     rem_in = {8'd0, hs_shift[31:8]};
                     hs_in  = 32'd0;
                     if (hs_shift[31:8] == 24'd0) begin
                        phase_in = PH_SIZE0;
                     end else begin
                        pc_in    = '0;
                        phase_in = PH_FLAGS;
                     end
                  end
               end
               PH_SIZE3: begin
                  rem_in   = hs_shift;
                  hs_in    = 32'd0;
                  pc_in    = '0;
                  phase_in = (hs_shift == 32'd0) ? PH_HDR0 : PH_FLAGS;
                  if (hs_shift == 32'd0) begin
                     run_in = '0;
                  end
               end
               PH_FLAGS: begin
                  flag_in  = b;
                  fidx_in  = 3'd7;
                  phase_in = PH_TOKEN;
               end
               PH_TOKEN: begin
                  if (!flag_ff[fidx_ff]) begin
                     // literal byte
                     a_status = ST_BYTE;
                     a_lit    = b;
                     a_prod   = 1'b1;
                     if (!at_end) begin
                        if (fidx_ff == 3'd0) begin
                           phase_in = PH_FLAGS;
                        end else begin
                           fidx_in  = fidx_ff - 3'd1;
                           phase_in = PH_TOKEN;
                        end
                     end
                  end else begin
                     tok_in = {16'd0, b};
                     if (!ext_ff || b[7:4] >= 4'd2) begin
                        phase_in = PH_OFS2;
                     end else if (b[7:4] == 4'd0) begin
                        phase_in = PH_EXT3_B1;
                     end else begin
                        phase_in = PH_EXT4_B1;
                     end
                  end
               end
               PH_EXT3_B1, PH_EXT4_B1, PH_EXT4_B2: begin
                  tok_in   = {tok_ff[15:0], b};
                  phase_in = phase_type'(phase_ff + 4'd1);
               end
               PH_OFS2, PH_EXT3_OFS, PH_EXT4_OFS: begin
                  if (CW'(dist_calc) > pc_ff) begin
                     a_status = ST_BADOFS;
                     phase_in = PH_HDR0;
                     hs_in    = 32'd0;
                     run_in   = '0;
                  end else begin
                     dist_in = dist_calc;
                     run_in  = ({15'd0, num} < rem_ff) ? num : rem_ff[RUN_W-1:0];
                     if (fidx_ff == 3'd0) begin
                        phase_in = PH_FLAGS;
                     end else begin
                        fidx_in  = fidx_ff - 3'd1;
                        phase_in = PH_TOKEN;
                     end
                  end
               end
               default: begin
                  phase_in = PH_HDR0;
               end
            endcase
         end
         // one byte goes into history
         if (a_prod) begin
            wp_in  = wp_ff + AW'(1);
            pc_in  = (pc_ff == DEPTH_C) ? pc_ff : pc_ff + CW'(1);
            rem_in = rem_dec;
            if (at_end) begin
               a_last   = 1'b1;
               phase_in = PH_HDR0;
               hs_in    = 32'd0;
               run_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         hs_ff    <= 32'd0;
         rem_ff   <= 32'd0;
         ext_ff   <= 1'b0;
         flag_ff  <= 8'd0;
         fidx_ff  <= 3'd7;
         tok_ff   <= 24'd0;
         run_ff   <= '0;
         dist_ff  <= DIST_W'(1);
         wp_ff    <= '0;
         pc_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         hs_ff    <= hs_in;
         rem_ff   <= rem_in;
         ext_ff   <= ext_in;
         flag_ff  <= flag_in;
         fidx_ff  <= fidx_in;
         tok_ff   <= tok_in;
         run_ff   <= run_in;
         dist_ff  <= dist_in;
         wp_ff    <= wp_in;
         pc_ff    <= pc_in;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         b_status_ff <= a_status;
         b_lit_ff    <= a_lit;
         b_last_ff   <= a_last;
         b_wr_ff     <= a_prod;
         b_ram_ff    <= a_ram;
         b_fwd_ff    <= fwd;
         b_waddr_ff  <= wp_ff;
      end
   end

   // out byte is the literal, or a copy byte from history or from the byte written just ahead of it
   assign b_byte = !b_ram_ff ? b_lit_ff : (b_fwd_ff ? last_byte_ff : ram_q_ff);
   assign wr_en  = b_valid_ff && rsp_tready && b_wr_ff;

   // history ring
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[b_waddr_ff] <= b_byte;
      end
      if (fire && a_ram) begin
         ram_q_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_byte_ff <= b_byte;
      end
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = b_byte;
   assign rsp_tuser  = b_status_ff;
   assign rsp_tlast  = b_last_ff;

endmodule

`default_nettype wire

>>> rtl/lz77_flag_token_decompressor.sv
// channel   dir  payload
// req       in   tuser[0] req_type, tdata[7:0] in_byte
// rsp       out  tuser[2:0] status, tdata[7:0] out_byte, tlast last
// csr       in   apb, register 0 at byte 0: algorithm_id[3:0]
//
// one request per cycle sustained while rsp_tready is high; a result is valid the cycle after
// the back part takes its queue beat; a request passes a queue slot and the result register
// one history ram read and one write per cycle set that rate; copy reads right behind
// the previous write are forwarded from the result stage
// a two-entry queue parts the request side from the parser; the result register
// stalls the parser only when rsp_tready is low
// synchronous reset clears control state; history contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module lz77_flag_token_decompressor #(
   parameter int HISTORY_DEPTH = 4096
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,    // in_byte
   input  wire  [0:0]  req_tuser,    // req_type
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,    // out_byte
   output logic [2:0]  rsp_tuser,    // status
   output logic        rsp_tlast,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [1:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lzfd_pkg::*;

   logic [3:0] alg_id_ff, alg_id_in;
   logic       q_valid, q_ready;
   item_type   q_item;

   // configuration register
   assign csr_pready = 1'b1;
   always_comb begin
      alg_id_in = alg_id_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_ALG_ADDR) begin
         alg_id_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alg_id_ff <= ALG_RESET;
      end else begin
         alg_id_ff <= alg_id_in;
      end
   end

   assign csr_prdata = (csr_paddr == CSR_ALG_ADDR) ? {28'd0, alg_id_ff} : 32'd0;

   lzfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   lzfd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .alg_id     (alg_id_ff),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> rtl/lzfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lzfd_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire  [7:0] rsp_tdata,
   input wire  [2:0] rsp_tuser,
   input wire        rsp_tlast
);
   import lzfd_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // end of stream only on a produced byte
   a_last_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == ST_BYTE)
      else $error("tlast without a byte");

   // data is zero unless a byte is produced
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_BYTE |-> rsp_tdata == 8'd0)
      else $error("data on a non-byte result");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind lz77_flag_token_decompressor lzfd_checker u_lzfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
